// File: src/nearest_one_approx_multiplier_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-one approximate multiplier
// Each macro checks in the clk domain and stays quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_ONE_APPROX_MULTIPLIER_DEFINES_SVH
`define NEAREST_ONE_APPROX_MULTIPLIER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define NOAM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NOAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/noam_pkg.sv
// ----------------------------------------------------------------------------
// noam_pkg
// Widths, types, constants and the power-of-two rounding function.
// ----------------------------------------------------------------------------
package noam_pkg;

  localparam int OPW  = 32;  // operand width
  localparam int PRW  = 64;  // product width
  localparam int KW   = 5;   // exponent of the nearest power of two, 0..31
  localparam int QW   = 33;  // signed offset from that power of two
  localparam int SOAW = 11;  // low bits fixed by the set-one adder

  localparam logic [SOAW-1:0] SOA_LOW_BITS = 11'h2AA;

  typedef logic [OPW-1:0]         opnd_t;
  typedef logic [PRW-1:0]         prod_t;
  typedef logic [KW-1:0]          k_t;
  typedef logic signed [QW-1:0]   q_t;

  // Leading one at p >= 2 gives p, or p+1 when bit p-1 is also set.
  // Leading one at bit 1 or 0, and zero, give 0.
  function automatic k_t nearest_power(input opnd_t mag);
    k_t k;
    k = '0;
    for (int i = 1; i <= OPW - 2; i++) begin
      if (mag[i+1]) begin
        k = mag[i] ? KW'(i + 2) : KW'(i + 1);
      end
    end
    return k;
  endfunction

endpackage

// File: src/noam_in_if.sv
// ----------------------------------------------------------------------------
// noam_in_if
// Operand channel: valid/ready with both multiplicands and the word flag.
// ----------------------------------------------------------------------------
interface noam_in_if;
  logic             valid;
  logic             ready;
  noam_pkg::opnd_t  operand_a;
  noam_pkg::opnd_t  operand_b;
  logic             word_mode;

  modport source (output valid, output operand_a, output operand_b,
                  output word_mode, input ready);
  modport sink   (input valid, input operand_a, input operand_b,
                  input word_mode, output ready);
endinterface

// File: src/noam_out_if.sv
// ----------------------------------------------------------------------------
// noam_out_if
// Result channel: valid/ready with the 64-bit product.
// ----------------------------------------------------------------------------
interface noam_out_if;
  logic             valid;
  logic             ready;
  noam_pkg::prod_t  product;

  modport source (output valid, output product, input ready);
  modport sink   (input valid, input product, output ready);
endinterface

// File: src/nearest_one_approx_multiplier.sv
// ----------------------------------------------------------------------------
// nearest_one_approx_multiplier: approximate signed 32x32 multiply
// Pipeline: six register stages, s1 to s6; the product is driven from stage 6.
// Throughput: one word per cycle unless out_chan.ready stalls; each stage has its own ready, so bubbles fill.
// Reset: synchronous rst_n clears the valid bits and the adder mode register.
// ----------------------------------------------------------------------------
`include "nearest_one_approx_multiplier_defines.svh"

module nearest_one_approx_multiplier (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  noam_in_if.sink           in_chan,
  noam_out_if.source        out_chan
);

  // configuration
  logic soa_mode_r;

  // stage valids and per-stage ready
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  // stage 1: magnitudes
  noam_pkg::opnd_t s1_mag_a_r, s1_mag_b_r, s1_mag_a_nxt, s1_mag_b_nxt;
  logic            s1_neg_r, s1_word_r;
  // stage 2: exponents
  noam_pkg::k_t    s2_ka_r, s2_kb_r;
  noam_pkg::opnd_t s2_mag_a_r, s2_mag_b_r;
  logic            s2_neg_r, s2_word_r;
  // stage 3: offsets
  noam_pkg::q_t    s3_qa_r, s3_qb_r, s3_qa_nxt, s3_qb_nxt;
  noam_pkg::k_t    s3_ka_r, s3_kb_r;
  logic            s3_neg_r, s3_word_r;
  // stage 4: the three addends
  noam_pkg::prod_t s4_base_r, s4_ta_r, s4_tb_r, s4_base_nxt, s4_ta_nxt, s4_tb_nxt;
  logic            s4_neg_r, s4_word_r;
  logic [noam_pkg::KW:0] ksum;
  // stage 5: sum
  noam_pkg::prod_t s5_sum_r, s5_sum_nxt;
  logic            s5_neg_r, s5_word_r, s5_soa_r;
  logic [noam_pkg::PRW-noam_pkg::SOAW-1:0] soa_hi;
  logic            soa_carry;
  // stage 6: sign and word mode
  noam_pkg::prod_t s6_prod_r, s6_prod_nxt, signed_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soa_mode_r <= 1'b0;
    end else if (cfg_we) begin
      soa_mode_r <= cfg_wdata;
    end
  end

  // a stage takes a new word when it is empty or its word moves on
  assign rdy6 = !s6_v_r || out_chan.ready;
  assign rdy5 = !s5_v_r || rdy6;
  assign rdy4 = !s4_v_r || rdy5;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;

  assign in_chan.ready  = rdy1;
  assign out_chan.valid = s6_v_r;
  assign out_chan.product = s6_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_chan.valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
      if (rdy5) s5_v_r <= s4_v_r;
      if (rdy6) s6_v_r <= s5_v_r;
    end
  end

  // stage 1 -------------------------------------------------------------
  always_comb begin
    s1_mag_a_nxt = in_chan.operand_a[noam_pkg::OPW-1] ?
                   (~in_chan.operand_a + noam_pkg::OPW'(1)) : in_chan.operand_a;
    s1_mag_b_nxt = in_chan.operand_b[noam_pkg::OPW-1] ?
                   (~in_chan.operand_b + noam_pkg::OPW'(1)) : in_chan.operand_b;
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_chan.valid) begin
      s1_mag_a_r <= s1_mag_a_nxt;
      s1_mag_b_r <= s1_mag_b_nxt;
      s1_neg_r   <= in_chan.operand_a[noam_pkg::OPW-1] ^ in_chan.operand_b[noam_pkg::OPW-1];
      s1_word_r  <= in_chan.word_mode;
    end
  end

  // stage 2 -------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rdy2 && s1_v_r) begin
      s2_ka_r    <= noam_pkg::nearest_power(s1_mag_a_r);
      s2_kb_r    <= noam_pkg::nearest_power(s1_mag_b_r);
      s2_mag_a_r <= s1_mag_a_r;
      s2_mag_b_r <= s1_mag_b_r;
      s2_neg_r   <= s1_neg_r;
      s2_word_r  <= s1_word_r;
    end
  end

  // stage 3 -------------------------------------------------------------
  always_comb begin
    s3_qa_nxt = $signed({1'b0, s2_mag_a_r}) - $signed(noam_pkg::QW'(1) << s2_ka_r);
    s3_qb_nxt = $signed({1'b0, s2_mag_b_r}) - $signed(noam_pkg::QW'(1) << s2_kb_r);
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v_r) begin
      s3_qa_r   <= s3_qa_nxt;
      s3_qb_r   <= s3_qb_nxt;
      s3_ka_r   <= s2_ka_r;
      s3_kb_r   <= s2_kb_r;
      s3_neg_r  <= s2_neg_r;
      s3_word_r <= s2_word_r;
    end
  end

  // stage 4 -------------------------------------------------------------
  always_comb begin
    ksum        = {1'b0, s3_ka_r} + {1'b0, s3_kb_r};
    s4_base_nxt = noam_pkg::PRW'(1) << ksum;
    // offsets are sign-extended, each shifted by the other operand's exponent
    s4_ta_nxt   = {{(noam_pkg::PRW-noam_pkg::QW){s3_qa_r[noam_pkg::QW-1]}}, s3_qa_r}
                  << s3_kb_r;
    s4_tb_nxt   = {{(noam_pkg::PRW-noam_pkg::QW){s3_qb_r[noam_pkg::QW-1]}}, s3_qb_r}
                  << s3_ka_r;
  end

  always_ff @(posedge clk) begin
    if (rdy4 && s3_v_r) begin
      s4_base_r <= s4_base_nxt;
      s4_ta_r   <= s4_ta_nxt;
      s4_tb_r   <= s4_tb_nxt;
      s4_neg_r  <= s3_neg_r;
      s4_word_r <= s3_word_r;
    end
  end

  // stage 5 -------------------------------------------------------------
  always_comb begin
    // carry into bit 11 when two or more addends have bit 10 set
    soa_carry = (s4_base_r[noam_pkg::SOAW-1] & s4_ta_r[noam_pkg::SOAW-1]) |
                (s4_base_r[noam_pkg::SOAW-1] & s4_tb_r[noam_pkg::SOAW-1]) |
                (s4_ta_r[noam_pkg::SOAW-1]   & s4_tb_r[noam_pkg::SOAW-1]);
    soa_hi    = s4_base_r[noam_pkg::PRW-1:noam_pkg::SOAW]
              + s4_ta_r[noam_pkg::PRW-1:noam_pkg::SOAW]
              + s4_tb_r[noam_pkg::PRW-1:noam_pkg::SOAW]
              + {{(noam_pkg::PRW-noam_pkg::SOAW-1){1'b0}}, soa_carry};
    if (soa_mode_r) begin
      s5_sum_nxt = {soa_hi, noam_pkg::SOA_LOW_BITS};
    end else begin
      s5_sum_nxt = s4_base_r + s4_ta_r + s4_tb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && s4_v_r) begin
      s5_sum_r  <= s5_sum_nxt;
      s5_neg_r  <= s4_neg_r;
      s5_word_r <= s4_word_r;
      s5_soa_r  <= soa_mode_r;
    end
  end

  // stage 6 -------------------------------------------------------------
  always_comb begin
    signed_sum = s5_neg_r ? (~s5_sum_r + noam_pkg::PRW'(1)) : s5_sum_r;
    if (s5_word_r) begin
      s6_prod_nxt = {{(noam_pkg::PRW-noam_pkg::OPW){signed_sum[noam_pkg::OPW-1]}},
                     signed_sum[noam_pkg::OPW-1:0]};
    end else begin
      s6_prod_nxt = signed_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6 && s5_v_r) begin
      s6_prod_r <= s6_prod_nxt;
    end
  end

  // checks ----------------------------------------------------------------
  `NOAM_ASSERT_NEXT(a_accept_fills_s1, in_chan.valid && in_chan.ready, s1_v_r,
                    "accepted operand word did not reach stage 1")
  `NOAM_ASSERT_NOW(a_k_not_one, s2_v_r && (s2_ka_r != '0), s2_ka_r[noam_pkg::KW-1:1] != '0,
                   "nearest power exponent of 1 is impossible")
  `NOAM_ASSERT_NOW(a_base_onehot, s4_v_r, $onehot(s4_base_r),
                   "power-of-two addend is not one-hot")
  `NOAM_ASSERT_NEXT(a_s5_hold, s5_v_r && !rdy5, s5_v_r && $stable(s5_sum_r),
                    "stalled sum in stage 5 was lost or changed")
  `NOAM_ASSERT_NOW(a_soa_low_bits, s5_v_r && s5_soa_r,
                   s5_sum_r[noam_pkg::SOAW-1:0] == noam_pkg::SOA_LOW_BITS,
                   "set-one adder low bits are wrong")

endmodule
